// ===== src/rle_pkg.sv =====
// Shared types for the run-length row decoder.
// Holds the decode phase codes, the controller state type and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package rle_pkg;

  // Decode phase kept between coded bytes
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_ACCEPT = 2'b01,
    ST_EMIT   = 2'b10
  } ctrl_state_t;

  localparam int unsigned CountW = 7;
  localparam int unsigned ByteW  = 8;

  // Controller to datapath
  typedef struct packed {
    logic load_input;   // take the coded byte and produce its first result
    logic load_repeat;  // produce the next pair of a repeat run
  } rle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_valid;    // result register holds an untaken result
    logic more;         // a byte taken now starts a run longer than one result
    logic emit_last;    // the next repeat result is the last of the run
  } rle_status_t;

endpackage : rle_pkg

`default_nettype wire

// ===== src/rle_ctrl.sv =====
// Controller for the run-length row decoder.
// Sequences input transfers and repeat-run emission; depends on rle_pkg.
`default_nettype none

module rle_ctrl import rle_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        out_ready,
  input  wire rle_status_t status,
  output rle_cmd_t         cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        slot_free;

  // Result register can take a new result this cycle
  assign slot_free = !status.out_valid || out_ready;

  assign in_ready        = (state == ST_ACCEPT) && slot_free;
  assign cmd.load_input  = in_valid && in_ready;
  assign cmd.load_repeat = (state == ST_EMIT) && slot_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCEPT: begin
        if (cmd.load_input && status.more) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.load_repeat && status.emit_last) begin
          state_next = ST_ACCEPT;
        end
      end
      default: state_next = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

endmodule : rle_ctrl

`default_nettype wire

// ===== src/rle_datapath.sv =====
// Datapath for the run-length row decoder: phase and count registers,
// repeat-run counter and the result register. Depends on rle_pkg.
`default_nettype none

module rle_datapath import rle_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rle_cmd_t         cmd,
  output rle_status_t           status,
  input  wire logic [ByteW-1:0] code_byte,
  input  wire logic             row_last,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [ByteW-1:0]      byte_first,
  output logic [ByteW-1:0]      byte_second,
  output logic [1:0]            byte_count,
  output logic                  input_done,
  output logic                  row_done,
  output logic                  bad_count
);

  phase_t            phase;
  phase_t            phase_next;
  logic [CountW-1:0] remaining;
  logic [CountW-1:0] remaining_next;
  logic [CountW-1:0] left;
  logic [CountW-1:0] left_next;
  logic [ByteW-1:0]  rep_byte;
  logic              last_q;

  // Result fields computed for the current command
  logic [ByteW-1:0]  res_first;
  logic [ByteW-1:0]  res_second;
  logic [1:0]        res_count;
  logic              res_idone;
  logic              res_rdone;
  logic              res_bad;

  // Repeat pair taken from a count
  logic [CountW-1:0] run_src;
  logic [ByteW-1:0]  run_byte;
  logic              run_last;
  logic              run_two;
  logic [CountW-1:0] run_left;

  assign status.out_valid = out_valid;
  assign status.more      = (phase == PH_REPEAT) && (remaining > CountW'(2));
  assign status.emit_last = (left <= CountW'(2));

  // Pick the repeat source: fresh count on input, running count otherwise
  always_comb begin
    if (cmd.load_input) begin
      run_src  = remaining;
      run_byte = code_byte;
      run_last = row_last;
    end else begin
      run_src  = left;
      run_byte = rep_byte;
      run_last = last_q;
    end
    run_two  = (run_src >= CountW'(2));
    run_left = run_src - (run_two ? CountW'(2) : CountW'(1));
  end

  // Decode one coded byte, or the next repeat pair
  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    left_next      = left;
    res_first      = '0;
    res_second     = '0;
    res_count      = 2'd0;
    res_idone      = 1'b1;
    res_rdone      = row_last;
    res_bad        = 1'b0;
    if (cmd.load_input) begin
      unique case (phase)
        PH_HEADER: begin
          if (code_byte[CountW-1:0] == '0) begin
            phase_next     = PH_SKIP;
            remaining_next = '0;
            res_bad        = 1'b1;
          end else begin
            phase_next     = code_byte[ByteW-1] ? PH_LITERAL : PH_REPEAT;
            remaining_next = code_byte[CountW-1:0];
          end
        end
        PH_LITERAL: begin
          res_first      = code_byte;
          res_count      = 2'd1;
          remaining_next = remaining - CountW'(1);
          if (remaining_next == '0) begin
            phase_next = PH_HEADER;
          end
        end
        PH_REPEAT: begin
          if (remaining != '0) begin
            res_first  = run_byte;
            res_second = run_two ? run_byte : '0;
            res_count  = run_two ? 2'd2 : 2'd1;
            res_idone  = (run_left == '0);
            res_rdone  = res_idone && run_last;
            left_next  = run_left;
          end
          phase_next     = PH_HEADER;
          remaining_next = '0;
        end
        PH_SKIP: begin
          res_bad = 1'b1;
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
      // Row end returns to header phase
      if (row_last) begin
        phase_next     = PH_HEADER;
        remaining_next = '0;
      end
    end else if (cmd.load_repeat) begin
      res_first  = run_byte;
      res_second = run_two ? run_byte : '0;
      res_count  = run_two ? 2'd2 : 2'd1;
      res_idone  = (run_left == '0);
      res_rdone  = res_idone && run_last;
      left_next  = run_left;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      remaining <= '0;
      left      <= '0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
      left      <= left_next;
      if (cmd.load_input || cmd.load_repeat) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold run byte and result fields
  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      rep_byte <= code_byte;
      last_q   <= row_last;
    end
    if (cmd.load_input || cmd.load_repeat) begin
      byte_first  <= res_first;
      byte_second <= res_second;
      byte_count  <= res_count;
      input_done  <= res_idone;
      row_done    <= res_rdone;
      bad_count   <= res_bad;
    end
  end

endmodule : rle_datapath

`default_nettype wire

// ===== src/rle_row_decoder_top.sv =====
// Run-length row decoder: one coded byte per input transfer, up to two
// decoded bytes per result transfer. Results are registered in the cycle
// after the input transfer. Unless stalled, header, literal and skip bytes
// give one result and sustain one byte per cycle; a repeat value with count
// n gives ceil(n/2) results, one per cycle from the result register; input is
// held off until the last one is loaded. Synchronous reset returns to header.
`default_nettype none

module rle_row_decoder_top import rle_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ByteW-1:0] code_byte,
  input  wire logic             row_last,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [ByteW-1:0]      byte_first,
  output logic [ByteW-1:0]      byte_second,
  output logic [1:0]            byte_count,
  output logic                  input_done,
  output logic                  row_done,
  output logic                  bad_count
);

  rle_cmd_t    cmd;
  rle_status_t status;

  rle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rle_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .code_byte   (code_byte),
    .row_last    (row_last),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .byte_first  (byte_first),
    .byte_second (byte_second),
    .byte_count  (byte_count),
    .input_done  (input_done),
    .row_done    (row_done),
    .bad_count   (bad_count)
  );

endmodule : rle_row_decoder_top

`default_nettype wire

// ===== dv/tb_rle_row_decoder_top.sv =====
// Self-checking testbench for rle_row_decoder_top: drives coded row bytes over
// valid/ready, predicts decoded pairs and flags in its own decoder model and
// compares every result transfer. Depends on rle_pkg and the RTL under src.
module tb_rle_row_decoder_top;
  import rle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One decoded result as the block should present it
  typedef struct packed {
    logic [ByteW-1:0] first;
    logic [ByteW-1:0] second;
    logic [1:0]       count;
    logic             in_done;
    logic             r_done;
    logic             bad;
  } dec_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] code_byte = '0;
  logic             row_last = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ByteW-1:0] byte_first;
  logic [ByteW-1:0] byte_second;
  logic [1:0]       byte_count;
  logic             input_done;
  logic             row_done;
  logic             bad_count;

  // Decoder model state
  phase_t            pred_phase = PH_HEADER;
  logic [CountW-1:0] pred_left = '0;
  dec_result_t       due_results[$];

  int err_count   = 0;
  int bytes_sent  = 0;
  int hold_cycles = 0;
  int ready_mode  = 0;
  int mode_left   = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;

  rle_row_decoder_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .code_byte   (code_byte),
    .row_last    (row_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_first  (byte_first),
    .byte_second (byte_second),
    .byte_count  (byte_count),
    .input_done  (input_done),
    .row_done    (row_done),
    .bad_count   (bad_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_error(string msg);
    if (err_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic push_result(logic [7:0] b0, logic [7:0] b1, logic [1:0] cnt,
                             logic idone, logic rdone, logic bad);
    dec_result_t r;
    r.first   = b0;
    r.second  = b1;
    r.count   = cnt;
    r.in_done = idone;
    r.r_done  = rdone;
    r.bad     = bad;
    due_results.push_back(r);
  endtask

  // Advance the decoder model by one coded byte and queue what it emits
  task automatic decode_byte(logic [7:0] b, logic last);
    logic [CountW-1:0] left;
    logic [1:0]        take;
    logic              fin;
    int                n;
    n = 0;
    case (pred_phase)
      PH_HEADER: begin
        if (b[6:0] == '0) begin
          pred_phase = PH_SKIP;
          pred_left  = '0;
          push_result(8'h00, 8'h00, 2'd0, 1'b1, last, 1'b1);
        end else begin
          pred_phase = b[7] ? PH_LITERAL : PH_REPEAT;
          pred_left  = b[6:0];
          push_result(8'h00, 8'h00, 2'd0, 1'b1, last, 1'b0);
        end
      end
      PH_LITERAL: begin
        push_result(b, 8'h00, 2'd1, 1'b1, last, 1'b0);
        pred_left = pred_left - 1'b1;
        if (pred_left == '0) pred_phase = PH_HEADER;
      end
      PH_REPEAT: begin
        left = pred_left;
        while (left != '0) begin
          take = (left >= 2) ? 2'd2 : 2'd1;
          left = left - take;
          fin  = (left == '0);
          push_result(b, (take == 2'd2) ? b : 8'h00, take, fin, fin & last, 1'b0);
          n++;
        end
        if (n == 0) push_result(8'h00, 8'h00, 2'd0, 1'b1, last, 1'b0);
        pred_phase = PH_HEADER;
        pred_left  = '0;
      end
      default: begin
        push_result(8'h00, 8'h00, 2'd0, 1'b1, last, 1'b1);
      end
    endcase
    if (last) begin
      pred_phase = PH_HEADER;
      pred_left  = '0;
    end
  endtask

  // Offer one coded byte and hold it until the transfer; valid stays high after
  task automatic send_item(logic [7:0] b, logic last);
    @(negedge clk);
    in_valid  <= 1'b1;
    code_byte <= b;
    row_last  <= last;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Send in bursts with random gaps between them while gaps_on is set
  task automatic send_bursty(logic [7:0] b, logic last);
    if (burst_left == 0) begin
      if (gaps_on) idle_input($urandom_range(1, 6));
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_item(b, last);
  endtask

  function automatic logic [6:0] pick_count();
    if ($urandom_range(0, 19) == 0) return 7'($urandom_range(64, 127));
    return 7'($urandom_range(1, 8));
  endfunction

  // Receiver: long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic check_field(string name, int got, int want);
    if (got != want) report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    dec_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_error("result transfer with nothing expected");
      end else begin
        want = due_results.pop_front();
        check_field("byte_first", byte_first, want.first);
        check_field("byte_second", byte_second, want.second);
        check_field("byte_count", byte_count, want.count);
        check_field("input_done", input_done, want.in_done);
        check_field("row_done", row_done, want.r_done);
        check_field("bad_count", bad_count, want.bad);
      end
    end
  end

  // Literal runs: extremes of the byte values, runs whose count ends on a row end
  task automatic test_literal_runs();
    send_item(8'h83, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b1);
    send_item(8'h81, 1'b0);
    send_item(8'hA5, 1'b1);
  endtask

  // Repeat runs: single byte, odd and even counts, the longest run
  task automatic test_repeat_runs();
    send_item(8'h01, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(8'hC3, 1'b1);
  endtask

  // Zero count headers with either top bit, skipped bytes, error as last byte
  task automatic test_zero_count();
    send_item(8'h00, 1'b0);
    send_item(8'h85, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h80, 1'b1);
  endtask

  // Row end on a header, inside a literal run and on a repeat value
  task automatic test_row_end_cases();
    send_item(8'h85, 1'b1);
    send_item(8'h05, 1'b1);
    send_item(8'h84, 1'b0);
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b1);
    send_item(8'h03, 1'b0);
    send_item(8'h77, 1'b1);
  endtask

  // Hold the receiver off while a long repeat and a literal run are offered
  task automatic test_backpressure();
    hold_cycles = 150;
    send_item(8'h7F, 1'b0);
    send_item(8'h3C, 1'b0);
    send_item(8'h83, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(8'h03, 1'b1);
  endtask

  // Mostly well-formed rows with random content, plus noise and broken rows
  task automatic test_random_rows(int n_bytes);
    int          stop_at;
    int          runs;
    int          kind;
    int          cut;
    bit          fin;
    logic [6:0]  cnt;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_bursty(8'($urandom), ($urandom_range(0, 2) == 0));
      end else begin
        runs = $urandom_range(1, 6);
        for (int r = 0; r < runs; r++) begin
          fin  = (r == runs - 1);
          kind = $urandom_range(0, 99);
          cnt  = pick_count();
          if (kind < 45) begin
            send_bursty({1'b1, cnt}, 1'b0);
            for (int i = 0; i < cnt; i++) send_bursty(8'($urandom), fin && (i == cnt - 1));
          end else if (kind < 85) begin
            send_bursty({1'b0, cnt}, 1'b0);
            send_bursty(8'($urandom), fin);
          end else if (kind < 92) begin
            send_bursty({1'($urandom), 7'd0}, 1'b0);
            repeat ($urandom_range(0, 3)) send_bursty(8'($urandom), 1'b0);
            send_bursty(8'($urandom), 1'b1);
            break;
          end else if (kind < 96) begin
            send_bursty({1'($urandom), cnt}, 1'b1);
            break;
          end else begin
            if (cnt < 2) cnt = 2;
            cut = $urandom_range(0, cnt - 2);
            send_bursty({1'b1, cnt}, cut == 0);
            for (int i = 0; i < cut; i++) send_bursty(8'($urandom), i == cut - 1);
            break;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_literal_runs();
    test_repeat_runs();
    test_zero_count();
    test_row_end_cases();
    test_backpressure();
    test_random_rows(410);

    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
src/rle_pkg.sv
src/rle_ctrl.sv
src/rle_datapath.sv
src/rle_row_decoder_top.sv
dv/tb_rle_row_decoder_top.sv
